/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by rti_queue and rti_back.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/rti_pkg.sv */
// ----------------------------------------------------------------------------
// rti_pkg
// Widths, codes, types and helpers of the ray/triangle intersection block.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int COORD_W    = 21;
    localparam int VERT_W     = 63;
    localparam int EPS_W      = 32;
    localparam int DIST_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam int E_W   = COORD_W + 1;      // edge and origin offset
    localparam int PP_W  = COORD_W + E_W;    // dir * e2
    localparam int QP_W  = 2 * E_W;          // tv * e1
    localparam int P_W   = PP_W + 1;
    localparam int Q_W   = QP_W + 1;
    localparam int M_W   = E_W + P_W;        // dot term
    localparam int MW_W  = E_W + Q_W;        // e2.q term
    localparam int D_W   = M_W + 2;          // det, u, v
    localparam int W_W   = MW_W + 2;         // e2.q
    localparam int MAG_W = W_W;
    localparam int DEN_W = D_W - 1;
    localparam int FRAC_SH = 16;
    localparam int SH_W  = DEN_W + FRAC_SH;

    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = DIST_W / DIV_BITS;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [DIST_W-1:0] MISS_DIST = 32'hFFFF_0000;
    localparam logic [DIST_W-1:0] SAT_POS   = 32'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] SAT_NEG   = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_A,
        CFG_VERTEX_B,
        CFG_VERTEX_C,
        CFG_EPS
    } cfg_idx_t;

    typedef struct packed {
        logic             hit;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [DEN_W-1:0] den;
    } job_t;

    typedef struct packed {
        logic             q;
        logic [DEN_W-1:0] rem;
    } div_st_t;

    function automatic div_st_t div_step(input logic [DEN_W-1:0] rem,
                                         input logic [DEN_W-1:0] den,
                                         input logic             b);
        logic [DEN_W:0] t;
        div_st_t        r;
        t = {rem, b};
        if (t >= {1'b0, den}) begin
            t   = t - {1'b0, den};
            r.q = 1'b1;
        end else begin
            r.q = 1'b0;
        end
        r.rem = t[DEN_W-1:0];
        return r;
    endfunction

endpackage

/* hw/rtl/ray_triangle_intersect_top.sv */
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top
// Single-sided ray/triangle intersection against a configured triangle.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : register writes (vertex A, B, C, threshold); always ready.
//            Write only while no ray is in flight.
//   s_*    : one ray per transfer (origin and direction, Q13.8).
//   m_*    : one result per ray, in order: hit flag and Q16.16 distance,
//            -1.0 on a miss.
// Throughput is one ray per cycle while the receiver accepts results. A ray
// passes through the geometry pipeline, the job queue, the saturation
// check, sixteen divider stages at two quotient bits each, and the output
// register.
// When the receiver stalls, the back pipeline holds; the queue absorbs up to
// QUEUE_DEPTH jobs plus the front pipeline contents before s_ready drops.
// Reset clears all valid state and restores the register defaults
// (vertices zero, threshold one).
// ----------------------------------------------------------------------------
module ray_triangle_intersect_top import rti_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_ray_origin_x,
    input  logic signed [COORD_W-1:0] s_ray_origin_y,
    input  logic signed [COORD_W-1:0] s_ray_origin_z,
    input  logic signed [COORD_W-1:0] s_ray_dir_x,
    input  logic signed [COORD_W-1:0] s_ray_dir_y,
    input  logic signed [COORD_W-1:0] s_ray_dir_z,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_hit,
    output logic signed [DIST_W-1:0]  m_distance
);

    logic [VERT_W-1:0] vertex_a_reg, vertex_b_reg, vertex_c_reg;
    logic [EPS_W-1:0]  eps_reg;

    logic fq_valid, fq_ready, qb_valid, qb_ready;
    job_t fq_job, qb_job;
    logic [DIST_W-1:0] m_dist;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_a_reg <= '0;
            vertex_b_reg <= '0;
            vertex_c_reg <= '0;
            eps_reg      <= EPS_W'(1);
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_VERTEX_A: vertex_a_reg <= cfg_data[VERT_W-1:0];
                CFG_VERTEX_B: vertex_b_reg <= cfg_data[VERT_W-1:0];
                CFG_VERTEX_C: vertex_c_reg <= cfg_data[VERT_W-1:0];
                CFG_EPS:      eps_reg      <= cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    rti_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .org_x     (s_ray_origin_x),
        .org_y     (s_ray_origin_y),
        .org_z     (s_ray_origin_z),
        .dir_x     (s_ray_dir_x),
        .dir_y     (s_ray_dir_y),
        .dir_z     (s_ray_dir_z),
        .vertex_a  (vertex_a_reg),
        .vertex_b  (vertex_b_reg),
        .vertex_c  (vertex_c_reg),
        .eps       (eps_reg),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    rti_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_job)
    );

    rti_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (qb_valid),
        .job_ready    (qb_ready),
        .job          (qb_job),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_hit      (m_hit),
        .out_distance (m_dist)
    );

    assign m_distance = $signed(m_dist);

endmodule

/* hw/rtl/rti_front.sv */
// ----------------------------------------------------------------------------
// rti_front
// Geometry pipeline: edges, cross and dot products, hit classification.
// ----------------------------------------------------------------------------
module rti_front import rti_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] org_x,
    input  logic signed [COORD_W-1:0] org_y,
    input  logic signed [COORD_W-1:0] org_z,
    input  logic signed [COORD_W-1:0] dir_x,
    input  logic signed [COORD_W-1:0] dir_y,
    input  logic signed [COORD_W-1:0] dir_z,
    input  logic [VERT_W-1:0]         vertex_a,
    input  logic [VERT_W-1:0]         vertex_b,
    input  logic [VERT_W-1:0]         vertex_c,
    input  logic [EPS_W-1:0]          eps,
    output logic                      job_valid,
    input  logic                      job_ready,
    output job_t                      job
);

    logic en;
    logic [5:0] v_reg;

    logic signed [COORD_W-1:0] va [3];
    logic signed [COORD_W-1:0] vb [3];
    logic signed [COORD_W-1:0] vc [3];
    logic signed [COORD_W-1:0] org [3];
    logic signed [COORD_W-1:0] dir_in [3];

    logic signed [E_W-1:0]     e1_1_reg [3], e2_1_reg [3], tv_1_reg [3];
    logic signed [COORD_W-1:0] dir_1_reg [3];
    logic signed [E_W-1:0]     e1_2_reg [3], e2_2_reg [3], tv_2_reg [3];
    logic signed [COORD_W-1:0] dir_2_reg [3];
    logic signed [PP_W-1:0]    pa_reg [3], pb_reg [3];
    logic signed [QP_W-1:0]    qa_reg [3], qb_reg [3];
    logic signed [E_W-1:0]     e1_3_reg [3], e2_3_reg [3], tv_3_reg [3];
    logic signed [COORD_W-1:0] dir_3_reg [3];
    logic signed [P_W-1:0]     p_reg [3];
    logic signed [Q_W-1:0]     q_reg [3];
    logic signed [M_W-1:0]     md_reg [3], mu_reg [3], mv_reg [3];
    logic signed [MW_W-1:0]    mw_reg [3];
    logic signed [D_W-1:0]     det_reg, u_reg, v_reg5;
    logic signed [W_W-1:0]     w_reg;
    job_t                      job_reg;

    logic signed [D_W-1:0] eps_s;
    logic signed [W_W-1:0] uv;
    job_t                  job_next;

    assign en        = !v_reg[5] || job_ready;
    assign in_ready  = en;
    assign job_valid = v_reg[5];
    assign job       = job_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            va[k] = $signed(vertex_a[k*COORD_W +: COORD_W]);
            vb[k] = $signed(vertex_b[k*COORD_W +: COORD_W]);
            vc[k] = $signed(vertex_c[k*COORD_W +: COORD_W]);
        end
        org[0] = org_x;
        org[1] = org_y;
        org[2] = org_z;
        dir_in[0] = dir_x;
        dir_in[1] = dir_y;
        dir_in[2] = dir_z;
    end

    assign eps_s = $signed({{(D_W-EPS_W){1'b0}}, eps});
    assign uv    = W_W'(u_reg) + W_W'(v_reg5);

    always_comb begin
        job_next.hit = (det_reg >= eps_s) && (det_reg != '0) && (u_reg >= eps_s)
                    && (u_reg <= det_reg) && (v_reg5 >= eps_s) && (uv <= W_W'(det_reg));
        job_next.neg = w_reg[W_W-1];
        job_next.mag = w_reg[W_W-1] ? MAG_W'(-w_reg) : MAG_W'(w_reg);
        job_next.den = det_reg[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                e1_1_reg[k]  <= E_W'(vb[k]) - E_W'(va[k]);
                e2_1_reg[k]  <= E_W'(vc[k]) - E_W'(va[k]);
                tv_1_reg[k]  <= E_W'(org[k]) - E_W'(va[k]);
                dir_1_reg[k] <= dir_in[k];

                pa_reg[k] <= dir_1_reg[(k+1)%3] * e2_1_reg[(k+2)%3];
                pb_reg[k] <= dir_1_reg[(k+2)%3] * e2_1_reg[(k+1)%3];
                qa_reg[k] <= tv_1_reg[(k+1)%3] * e1_1_reg[(k+2)%3];
                qb_reg[k] <= tv_1_reg[(k+2)%3] * e1_1_reg[(k+1)%3];
                e1_2_reg[k]  <= e1_1_reg[k];
                e2_2_reg[k]  <= e2_1_reg[k];
                tv_2_reg[k]  <= tv_1_reg[k];
                dir_2_reg[k] <= dir_1_reg[k];

                p_reg[k] <= P_W'(pa_reg[k]) - P_W'(pb_reg[k]);
                q_reg[k] <= Q_W'(qa_reg[k]) - Q_W'(qb_reg[k]);
                e1_3_reg[k]  <= e1_2_reg[k];
                e2_3_reg[k]  <= e2_2_reg[k];
                tv_3_reg[k]  <= tv_2_reg[k];
                dir_3_reg[k] <= dir_2_reg[k];

                md_reg[k] <= e1_3_reg[k] * p_reg[k];
                mu_reg[k] <= tv_3_reg[k] * p_reg[k];
                mv_reg[k] <= dir_3_reg[k] * q_reg[k];
                mw_reg[k] <= e2_3_reg[k] * q_reg[k];
            end
            det_reg <= D_W'(md_reg[0]) + D_W'(md_reg[1]) + D_W'(md_reg[2]);
            u_reg   <= D_W'(mu_reg[0]) + D_W'(mu_reg[1]) + D_W'(mu_reg[2]);
            v_reg5  <= D_W'(mv_reg[0]) + D_W'(mv_reg[1]) + D_W'(mv_reg[2]);
            w_reg   <= W_W'(mw_reg[0]) + W_W'(mw_reg[1]) + W_W'(mw_reg[2]);
            job_reg <= job_next;
        end
    end

endmodule

/* hw/rtl/rti_queue.sv */
// ----------------------------------------------------------------------------
// rti_queue
// Small FIFO of classified jobs between the front and back pipelines.
// ----------------------------------------------------------------------------
module rti_queue import rti_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);
`include "assert_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push, pop;

    assign push_ready = cnt_reg != CNT_W'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `ASSERT_NEXT(a_cnt_up, aclk, aresetn, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)
    `ASSERT_NEXT(a_cnt_dn, aclk, aresetn, pop && !push, cnt_reg == $past(cnt_reg) - 1'b1)
    `ASSERT_IMPL(a_ptr_eq, aclk, aresetn, cnt_reg == '0, wr_ptr_reg == rd_ptr_reg)

endmodule

/* hw/rtl/rti_back.sv */
// ----------------------------------------------------------------------------
// rti_back
// Distance pipeline: saturation check, pipelined divider, output register.
// ----------------------------------------------------------------------------
module rti_back import rti_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    output logic              job_ready,
    input  job_t              job,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_hit,
    output logic [DIST_W-1:0] out_distance
);
`include "assert_macros.svh"

    typedef struct packed {
        logic              hit;
        logic              neg;
        logic              sat;
        logic [DEN_W-1:0]  den;
        logic [DEN_W-1:0]  rem;
        logic [DIST_W-1:0] low;
        logic [DIST_W-1:0] quo;
    } bst_t;

    logic                  en;
    logic [DIV_STAGES:0]   sv_reg;
    bst_t                  st_reg [DIV_STAGES+1];
    bst_t                  nxt [DIV_STAGES];
    bst_t                  b0;
    logic                  out_valid_reg, out_hit_reg;
    logic [DIST_W-1:0]     out_dist_reg, dist_next;
    bst_t                  fin;

    assign en        = !out_valid_reg || out_ready;
    assign job_ready = en;

    always_comb begin
        b0.hit = job.hit;
        b0.neg = job.neg;
        b0.sat = {{(SH_W-MAG_W){1'b0}}, job.mag} >= {job.den, {FRAC_SH{1'b0}}};
        b0.den = job.den;
        b0.rem = DEN_W'(job.mag >> FRAC_SH);
        b0.low = {job.mag[FRAC_SH-1:0], {(DIST_W-FRAC_SH){1'b0}}};
        b0.quo = '0;
    end

    always_comb begin
        div_st_t d;
        for (int i = 0; i < DIV_STAGES; i++) begin
            nxt[i] = st_reg[i];
            for (int j = 0; j < DIV_BITS; j++) begin
                d = div_step(nxt[i].rem, nxt[i].den, nxt[i].low[DIST_W-1]);
                nxt[i].rem = d.rem;
                nxt[i].low = {nxt[i].low[DIST_W-2:0], 1'b0};
                nxt[i].quo = {nxt[i].quo[DIST_W-2:0], d.q};
            end
        end
    end

    assign fin = st_reg[DIV_STAGES];

    always_comb begin
        if (!fin.hit) begin
            dist_next = MISS_DIST;
        end else if (fin.sat) begin
            dist_next = fin.neg ? SAT_NEG : SAT_POS;
        end else if (fin.neg) begin
            dist_next = (fin.quo >= SAT_NEG) ? SAT_NEG : (~fin.quo + 1'b1);
        end else begin
            dist_next = (fin.quo > SAT_POS) ? SAT_POS : fin.quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            sv_reg        <= {sv_reg[DIV_STAGES-1:0], job_valid};
            out_valid_reg <= sv_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= b0;
            for (int i = 0; i < DIV_STAGES; i++) begin
                st_reg[i+1] <= nxt[i];
            end
            out_hit_reg  <= fin.hit;
            out_dist_reg <= dist_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_hit      = out_hit_reg;
    assign out_distance = out_dist_reg;

    `ASSERT_IMPL(a_miss_dist, aclk, aresetn, out_valid_reg && !out_hit_reg,
        out_dist_reg == MISS_DIST)
    `ASSERT_NEXT(a_hold, aclk, aresetn, out_valid_reg && !out_ready,
        sv_reg == $past(sv_reg))

endmodule
